@@ sv/sdff_pkg.sv @@
// Shared types and constants for the signed decimal field formatter.
`timescale 1ns / 1ps

package sdff_pkg;

	localparam int VALUE_BITS = 64;
	localparam int BCD_DIGITS = 20;
	localparam int BCD_BITS   = 4 * BCD_DIGITS;
	localparam int STEP_BITS  = 7;
	localparam int NDIG_BITS  = 5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// operand size codes
	localparam logic [1:0] SIZE_8  = 2'd0;
	localparam logic [1:0] SIZE_16 = 2'd1;
	localparam logic [1:0] SIZE_32 = 2'd2;
	localparam logic [1:0] SIZE_64 = 2'd3;

	// control from the sequencer to the binary to BCD unit
	typedef struct packed {
		logic                 start;
		logic [STEP_BITS-1:0] steps;
	} conv_ctrl_t;

endpackage

@@ sv/sdff_if.sv @@
// Valid/ready channel interfaces for the formatter's input and output words.
`timescale 1ns / 1ps

interface sdff_in_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic [1:0]         size_code;
	logic [6:0]         field_width;
	logic signed [6:0]  precision;
	logic               left_just;
	logic               zero_pad;
	logic               plus_flag;
	logic               space_flag;

	modport source (output valid, value, size_code, field_width, precision, left_just,
		zero_pad, plus_flag, space_flag, input ready);
	modport sink (input valid, value, size_code, field_width, precision, left_just,
		zero_pad, plus_flag, space_flag, output ready);
endinterface

interface sdff_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last_char;

	modport source (output valid, character, last_char, input ready);
	modport sink (input valid, character, last_char, output ready);
endinterface

@@ sv/signed_decimal_field_formatter_top.sv @@
// After accept come 8/16/32/64 conversion steps by operand size, then the ST_SIZE and ST_PLAN
// states count digits and plan padding before ST_EMIT loads the first character word.
// The serial BCD unit and the single output register bound the rate of items; a new item is
// not taken while one is in flight, since input is not ready until the
// last character word of the field has been loaded into the output register.
// Reset: asynchronous, clears the sequencer and the output valid; no state survives an item.
`timescale 1ns / 1ps

module signed_decimal_field_formatter_top
	import sdff_pkg::*;
#(
	parameter int MAX_FIELD_CHARS = 64
) (
	input  logic clk,
	input  logic arst_n,
	sdff_in_if.sink    operand,
	sdff_out_if.source chars
);

	localparam int CW = $clog2(MAX_FIELD_CHARS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_PLAN,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic                   neg_q;
	logic                   left_q;
	logic                   zpad_q;
	logic                   plus_q;
	logic                   space_q;
	logic                   has_prec_q;
	logic [CW-1:0]          prec_q;
	logic [CW-1:0]          width_q;
	logic [NDIG_BITS-1:0]   ndig_q;
	logic                   sign_q;
	logic [CW-1:0]          zeros_q;
	logic [CW-1:0]          spaces_q;
	logic [CW-1:0]          rem_q;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;

	logic                   accept;
	logic                   neg;
	logic [VALUE_BITS-1:0]  sext;
	logic [VALUE_BITS-1:0]  mag;
	logic [VALUE_BITS-1:0]  aligned;
	logic [STEP_BITS-1:0]   steps;
	conv_ctrl_t             conv_ctrl;
	logic                   conv_done;
	logic [BCD_BITS-1:0]    bcd;
	logic [NDIG_BITS-1:0]   ndig;
	logic                   sign_len;
	logic signed [8:0]      zeros_s;
	logic signed [8:0]      spaces_s;
	logic [CW-1:0]          zeros_c;
	logic [CW-1:0]          spaces_c;
	logic [CW-1:0]          total_c;
	logic                   advance;
	logic [NDIG_BITS-1:0]   dig_idx;
	logic [7:0]             sign_char;

	assign accept        = operand.valid && operand.ready;
	assign operand.ready = (state_q == ST_IDLE);

	// cut to operand size, sign-extend, take the magnitude and left-align it
	always_comb begin
		unique case (operand.size_code)
			SIZE_8: begin
				sext    = {{56{operand.value[7]}}, operand.value[7:0]};
				neg     = operand.value[7];
			end
			SIZE_16: begin
				sext    = {{48{operand.value[15]}}, operand.value[15:0]};
				neg     = operand.value[15];
			end
			SIZE_32: begin
				sext    = {{32{operand.value[31]}}, operand.value[31:0]};
				neg     = operand.value[31];
			end
			default: begin
				sext    = operand.value;
				neg     = operand.value[63];
			end
		endcase
		mag   = neg ? (~sext + 64'd1) : sext;
		steps = STEP_BITS'(8) << operand.size_code;
		unique case (operand.size_code)
			SIZE_8:  aligned = mag << 56;
			SIZE_16: aligned = mag << 48;
			SIZE_32: aligned = mag << 32;
			default: aligned = mag;
		endcase
	end

	assign conv_ctrl.start = accept;
	assign conv_ctrl.steps = steps;

	sdff_dabble u_dabble (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (conv_ctrl),
		.operand (aligned),
		.done    (conv_done),
		.bcd     (bcd)
	);

	// count significant digits: highest non-zero digit, or one zero digit unless precision is 0
	always_comb begin
		ndig = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd[4*i +: 4] != 4'd0) begin
				ndig = NDIG_BITS'(i + 1);
			end
		end
		if (ndig == '0 && !(has_prec_q && prec_q == '0)) begin
			ndig = NDIG_BITS'(1);
		end
	end

	// plan the zero and space padding
	always_comb begin
		sign_len = neg_q || plus_q || space_q;
		if (has_prec_q) begin
			zeros_s = signed'(9'(prec_q)) - signed'(9'(ndig_q));
		end else if (!left_q && zpad_q) begin
			zeros_s = signed'(9'(width_q)) - signed'(9'(ndig_q)) - signed'(9'(sign_len));
		end else begin
			zeros_s = '0;
		end
		if (zeros_s < 0) begin
			zeros_s = '0;
		end
		spaces_s = signed'(9'(width_q)) - zeros_s - signed'(9'(ndig_q))
			- signed'(9'(sign_len));
		if (spaces_s < 0) begin
			spaces_s = '0;
		end
		zeros_c  = CW'(zeros_s);
		spaces_c = CW'(spaces_s);
		total_c  = zeros_c + spaces_c + CW'(ndig_q) + CW'(sign_len);
	end

	assign advance   = !out_valid_q || chars.ready;
	assign dig_idx   = ndig_q - 1'b1;
	assign sign_char = neg_q ? CH_MINUS : (plus_q ? CH_PLUS : CH_SPACE);

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ndig_q      <= '0;
			sign_q      <= 1'b0;
			zeros_q     <= '0;
			spaces_q    <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a word on advance, drop it once taken
			if (state_q == ST_EMIT && advance) begin
				out_valid_q <= 1'b1;
			end else if (chars.valid && chars.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					ndig_q  <= ndig;
					state_q <= ST_PLAN;
				end
				ST_PLAN: begin
					sign_q   <= sign_len;
					zeros_q  <= zeros_c;
					spaces_q <= spaces_c;
					rem_q    <= total_c;
					state_q  <= (total_c == '0) ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (advance) begin
						rem_q       <= rem_q - 1'b1;
						if (rem_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
						priority if (!left_q && spaces_q != '0) begin
							spaces_q <= spaces_q - 1'b1;
						end else if (sign_q) begin
							sign_q <= 1'b0;
						end else if (zeros_q != '0) begin
							zeros_q <= zeros_q - 1'b1;
						end else if (ndig_q != '0) begin
							ndig_q <= ndig_q - 1'b1;
						end else begin
							spaces_q <= spaces_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the spec and the outgoing character word
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q      <= neg;
			left_q     <= operand.left_just;
			zpad_q     <= operand.zero_pad;
			plus_q     <= operand.plus_flag;
			space_q    <= operand.space_flag;
			has_prec_q <= !operand.precision[6];
			if ({1'b0, operand.field_width} > 8'(MAX_FIELD_CHARS)) begin
				width_q <= CW'(MAX_FIELD_CHARS);
			end else begin
				width_q <= CW'(operand.field_width);
			end
			if ({2'b00, operand.precision[5:0]} > 8'(MAX_FIELD_CHARS - 1)) begin
				prec_q <= CW'(MAX_FIELD_CHARS - 1);
			end else begin
				prec_q <= CW'(operand.precision[5:0]);
			end
		end
		if (state_q == ST_EMIT && advance) begin
			last_q <= (rem_q == CW'(1));
			priority if (!left_q && spaces_q != '0) begin
				char_q <= CH_SPACE;
			end else if (sign_q) begin
				char_q <= sign_char;
			end else if (zeros_q != '0) begin
				char_q <= CH_ZERO;
			end else if (ndig_q != '0) begin
				char_q <= CH_ZERO | {4'd0, bcd[4*dig_idx +: 4]};
			end else begin
				char_q <= CH_SPACE;
			end
		end
	end

	assign chars.valid     = out_valid_q;
	assign chars.character = char_q;
	assign chars.last_char = last_q;

endmodule

@@ sv/sdff_dabble.sv @@
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
`timescale 1ns / 1ps

module sdff_dabble
	import sdff_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  conv_ctrl_t            ctrl,
	input  logic [VALUE_BITS-1:0] operand,
	output logic                  done,
	output logic [BCD_BITS-1:0]   bcd
);

	logic [VALUE_BITS-1:0] shift_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [STEP_BITS-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [BCD_BITS-1:0]   adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// count the steps and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctrl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the binary word into the BCD register
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			shift_q <= operand;
			bcd_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
			bcd_q   <= {adj[BCD_BITS-2:0], shift_q[VALUE_BITS-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
